// File: design/stepper_command_parser_stepgen_core_macros.svh
// Assertion helpers for the stepper command core.
`ifndef STEPPER_COMMAND_PARSER_STEPGEN_CORE_MACROS_SVH
`define STEPPER_COMMAND_PARSER_STEPGEN_CORE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SCPS_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("scps assertion failed");

// Next-cycle implication, checked outside reset.
`define SCPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scps assertion failed");

`endif

// File: design/scps_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package scps_pkg;

  localparam int COUNT_WIDTH_DEF = 32;

  // request kinds
  localparam logic REQ_BYTE = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // command characters
  localparam logic [7:0] CHAR_BAR  = 8'h7C;
  localparam logic [7:0] CHAR_E    = 8'h45;
  localparam logic [7:0] CHAR_D    = 8'h44;
  localparam logic [7:0] CHAR_S    = 8'h53;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_AFTER_E = 2'd1,
    MODE_AFTER_D = 2'd2,
    MODE_NUMBER  = 2'd3
  } parse_mode_t;

  // updates the parser asks the step generator to apply
  typedef struct packed {
    logic en_wr;
    logic en_val;
    logic dir_wr;
    logic dir_val;
    logic tgt_load;
    logic cmd_end;
  } parse_ctrl_t;

endpackage

`default_nettype wire

// File: design/scps_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface scps_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] byte_value;

  modport source (output valid, output req_type, output byte_value, input ready);
  modport sink   (input valid, input req_type, input byte_value, output ready);
endinterface

`default_nettype wire

// File: design/scps_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface scps_out_if;
  logic valid;
  logic ready;
  logic step_pulse;
  logic direction;
  logic axis_enabled;
  logic stop_event;
  logic command_end;

  modport source (output valid, output step_pulse, output direction, output axis_enabled,
                  output stop_event, output command_end, input ready);
  modport sink   (input valid, input step_pulse, input direction, input axis_enabled,
                  input stop_event, input command_end, output ready);
endinterface

`default_nettype wire

// File: design/stepper_command_parser_stepgen_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel | Dir | Payload                                            | Transfer
// in_ch   | in  | req_type, byte_value                               | valid && ready
// out_ch  | out | step_pulse, direction, axis_enabled, stop_event,   | valid && ready
//         |     | command_end                                        |
//
// One result per item, next cycle; one item per cycle while out_ch.ready is high.
// Parser and step counters update at the input transfer; the result register holds it.
// in_ch.ready stays high while the result register is empty or being drained.
// Synchronous active-low reset clears parse state, counters, flags and out_ch.valid.

module stepper_command_parser_stepgen_core #(
  parameter int COUNT_WIDTH = scps_pkg::COUNT_WIDTH_DEF
) (
  input wire logic clk,
  input wire logic rst_n,
  scps_in_if.sink    in_ch,
  scps_out_if.source out_ch
);
  import scps_pkg::*;

  parse_ctrl_t             ctrl;
  logic [COUNT_WIDTH-1:0]  accum;
  logic                    accept;
  logic                    byte_acc;

  logic                    enable_r, enable_nxt;
  logic                    direction_r, direction_nxt;
  logic [COUNT_WIDTH-1:0]  step_target_r, step_target_nxt;
  logic [COUNT_WIDTH-1:0]  steps_done_r, steps_done_nxt;
  logic                    pulse_nxt, stop_nxt;

  logic                    out_valid_r;
  logic                    pulse_r, stop_r, end_r, dir_out_r, en_out_r;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign accept      = in_ch.valid && in_ch.ready;
  assign byte_acc    = accept && (in_ch.req_type == REQ_BYTE);

  scps_parser #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .byte_en   (byte_acc),
    .byte_value(in_ch.byte_value),
    .ctrl      (ctrl),
    .accum     (accum)
  );

  always_comb begin
    enable_nxt      = enable_r;
    direction_nxt   = direction_r;
    step_target_nxt = step_target_r;
    steps_done_nxt  = steps_done_r;
    pulse_nxt       = 1'b0;
    stop_nxt        = 1'b0;
    if (in_ch.req_type == REQ_BYTE) begin
      if (ctrl.en_wr) begin
        enable_nxt = ctrl.en_val;
      end
      if (ctrl.dir_wr) begin
        direction_nxt = ctrl.dir_val;
      end
      if (ctrl.tgt_load) begin
        step_target_nxt = accum;
      end
    end else if (step_target_r != '0) begin
      if (steps_done_r != step_target_r) begin
        // wraps when the target was lowered below the done count
        steps_done_nxt = steps_done_r + 1'b1;
        pulse_nxt      = 1'b1;
      end else begin
        step_target_nxt = '0;
        steps_done_nxt  = '0;
        enable_nxt      = 1'b0;
        stop_nxt        = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r      <= 1'b0;
      direction_r   <= 1'b0;
      step_target_r <= '0;
      steps_done_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (accept) begin
        enable_r      <= enable_nxt;
        direction_r   <= direction_nxt;
        step_target_r <= step_target_nxt;
        steps_done_r  <= steps_done_nxt;
        out_valid_r   <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pulse_r   <= pulse_nxt;
      stop_r    <= stop_nxt;
      end_r     <= byte_acc && ctrl.cmd_end;
      dir_out_r <= direction_nxt;
      en_out_r  <= enable_nxt;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.step_pulse   = pulse_r;
  assign out_ch.direction    = dir_out_r;
  assign out_ch.axis_enabled = en_out_r;
  assign out_ch.stop_event   = stop_r;
  assign out_ch.command_end  = end_r;

endmodule

`default_nettype wire

// File: design/scps_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module scps_parser #(
  parameter int COUNT_WIDTH = scps_pkg::COUNT_WIDTH_DEF
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     byte_en,
  input  wire logic [7:0]               byte_value,
  output scps_pkg::parse_ctrl_t         ctrl,
  output logic [COUNT_WIDTH-1:0]        accum
);
  import scps_pkg::*;

  localparam int PW = COUNT_WIDTH + 4;

  parse_mode_t             mode_r, mode_nxt, idle_mode;
  logic [COUNT_WIDTH-1:0]  accum_r, accum_nxt;
  logic                    seen_r, seen_nxt;
  logic                    stopped_r, stopped_nxt;
  logic                    is_digit;
  logic [PW-1:0]           prod;
  logic [COUNT_WIDTH-1:0]  accum_sat;

  assign is_digit = (byte_value >= CHAR_ZERO) && (byte_value <= CHAR_NINE);

  // acc*10 + digit, saturate at all ones
  assign prod = ({4'b0, accum_r} << 3) + ({4'b0, accum_r} << 1) + PW'(byte_value[3:0]);
  assign accum_sat = (|prod[PW-1:COUNT_WIDTH]) ? {COUNT_WIDTH{1'b1}} : prod[COUNT_WIDTH-1:0];

  // mode reached when the byte is taken as a plain command byte
  always_comb begin
    unique case (byte_value)
      CHAR_E:  idle_mode = MODE_AFTER_E;
      CHAR_D:  idle_mode = MODE_AFTER_D;
      CHAR_S:  idle_mode = MODE_NUMBER;
      default: idle_mode = MODE_IDLE;
    endcase
  end

  // next state
  always_comb begin
    mode_nxt    = mode_r;
    accum_nxt   = accum_r;
    seen_nxt    = seen_r;
    stopped_nxt = stopped_r;
    unique case (mode_r)
      MODE_NUMBER: begin
        if (byte_value == CHAR_S) begin
          mode_nxt = MODE_IDLE;
        end else if (!stopped_r && is_digit) begin
          accum_nxt = accum_sat;
          seen_nxt  = 1'b1;
        end else begin
          stopped_nxt = 1'b1;
        end
      end
      default: begin
        mode_nxt = idle_mode;
        if (idle_mode == MODE_NUMBER) begin
          accum_nxt   = '0;
          seen_nxt    = 1'b0;
          stopped_nxt = 1'b0;
        end
      end
    endcase
  end

  // outputs
  always_comb begin
    ctrl = '0;
    unique case (mode_r)
      MODE_AFTER_E: begin
        ctrl.en_wr   = 1'b1;
        ctrl.en_val  = (byte_value == CHAR_ONE);
        ctrl.cmd_end = (byte_value == CHAR_BAR);
      end
      MODE_AFTER_D: begin
        ctrl.dir_wr  = 1'b1;
        ctrl.dir_val = (byte_value != CHAR_ONE);
        ctrl.cmd_end = (byte_value == CHAR_BAR);
      end
      MODE_NUMBER: begin
        ctrl.tgt_load = (byte_value == CHAR_S) && seen_r;
      end
      default: begin
        ctrl.cmd_end = (byte_value == CHAR_BAR);
      end
    endcase
  end

  assign accum = accum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_IDLE;
      accum_r   <= '0;
      seen_r    <= 1'b0;
      stopped_r <= 1'b0;
    end else if (byte_en) begin
      mode_r    <= mode_nxt;
      accum_r   <= accum_nxt;
      seen_r    <= seen_nxt;
      stopped_r <= stopped_nxt;
    end
  end

endmodule

`default_nettype wire

// File: design/scps_checker.sv
`timescale 1ns / 1ps
`default_nettype none

`include "stepper_command_parser_stepgen_core_macros.svh"

module scps_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire logic step_pulse,
  input wire logic axis_enabled,
  input wire logic stop_event,
  input wire logic command_end,
  input wire logic direction
);

  // a stalled result holds
  `SCPS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable({step_pulse, direction, axis_enabled, stop_event, command_end}))

  // a tick either steps or stops, never both
  `SCPS_ASSERT_NOW(a_pulse_stop_excl, clk, rst_n, out_valid, !(step_pulse && stop_event))

  // completing a move leaves the axis disabled
  `SCPS_ASSERT_NOW(a_stop_disables, clk, rst_n, out_valid && stop_event, !axis_enabled)

  // a command end comes from a byte, so no tick flags go with it
  `SCPS_ASSERT_NOW(a_end_is_byte, clk, rst_n, out_valid && command_end, !step_pulse && !stop_event)

  // every transfer in yields a result on the next cycle
  `SCPS_ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && in_ready, out_valid)

endmodule

bind stepper_command_parser_stepgen_core scps_checker u_scps_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .step_pulse  (out_ch.step_pulse),
  .axis_enabled(out_ch.axis_enabled),
  .stop_event  (out_ch.stop_event),
  .command_end (out_ch.command_end),
  .direction   (out_ch.direction)
);

`default_nettype wire

// File: sim/scps_step_checker.sv
`timescale 1ns / 1ps

module scps_step_checker #(
  parameter int CW = scps_pkg::COUNT_WIDTH_DEF
) (
  input  logic clk,
  input  logic rst_n,
  scps_in_if   in_ch,
  scps_out_if  out_ch,
  output int   error_count,
  output int   results_due
);
  import scps_pkg::*;

  localparam logic [CW-1:0] COUNT_MAX = {CW{1'b1}};

  typedef struct packed {
    logic pulse;
    logic dir;
    logic en;
    logic stop;
    logic cmd_end;
  } step_result_t;

  // parser and step generator state
  parse_mode_t   cmd_mode;
  logic [CW-1:0] num_acc;
  logic          num_has_digit;
  logic          num_closed;
  logic [CW-1:0] move_target;
  logic [CW-1:0] move_count;
  logic          axis_on;
  logic          dir_back;

  step_result_t step_results_q[$];
  int           mismatches;
  int           due_n;
  int           result_idx;

  assign error_count = mismatches;
  assign results_due = due_n;

  task automatic report_failure(input string msg);
    $display("step_chk: result %0d: %s", result_idx, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want)
      report_failure($sformatf("%s expected %0b got %0b", name, want, got));
  endtask

  function automatic logic idle_byte(logic [7:0] b);
    logic ends;
    ends = 1'b0;
    if (b == CHAR_E) begin
      cmd_mode = MODE_AFTER_E;
    end else if (b == CHAR_D) begin
      cmd_mode = MODE_AFTER_D;
    end else if (b == CHAR_S) begin
      cmd_mode      = MODE_NUMBER;
      num_acc       = '0;
      num_has_digit = 1'b0;
      num_closed    = 1'b0;
    end else if (b == CHAR_BAR) begin
      ends = 1'b1;
    end
    return ends;
  endfunction

  function automatic logic take_byte(logic [7:0] b);
    logic        ends;
    logic [63:0] wide;
    ends = 1'b0;
    case (cmd_mode)
      MODE_AFTER_E: begin
        axis_on  = (b == CHAR_ONE);
        cmd_mode = MODE_IDLE;
        ends     = idle_byte(b);
      end
      MODE_AFTER_D: begin
        dir_back = (b != CHAR_ONE);
        cmd_mode = MODE_IDLE;
        ends     = idle_byte(b);
      end
      MODE_NUMBER: begin
        if (b == CHAR_S) begin
          if (num_has_digit) move_target = num_acc;
          cmd_mode = MODE_IDLE;
        end else if (!num_closed && b >= CHAR_ZERO && b <= CHAR_NINE) begin
          wide = 64'(num_acc) * 64'd10 + 64'(b - CHAR_ZERO);
          // saturate at the counter maximum
          num_acc       = (wide > 64'(COUNT_MAX)) ? COUNT_MAX : wide[CW-1:0];
          num_has_digit = 1'b1;
        end else begin
          num_closed = 1'b1;
        end
      end
      default: ends = idle_byte(b);
    endcase
    return ends;
  endfunction

  function automatic step_result_t predict_step(logic rt, logic [7:0] b);
    step_result_t r;
    r = '0;
    if (rt == REQ_BYTE) begin
      r.cmd_end = take_byte(b);
    end else if (move_target != '0) begin
      if (move_count != move_target) begin
        move_count = move_count + 1'b1;
        r.pulse    = 1'b1;
      end else begin
        move_target = '0;
        move_count  = '0;
        axis_on     = 1'b0;
        r.stop      = 1'b1;
      end
    end
    r.dir = dir_back;
    r.en  = axis_on;
    return r;
  endfunction

  always @(posedge clk) begin : watch
    step_result_t got;
    step_result_t want;
    if (!rst_n) begin
      cmd_mode      = MODE_IDLE;
      num_acc       = '0;
      num_has_digit = 1'b0;
      num_closed    = 1'b0;
      move_target   = '0;
      move_count    = '0;
      axis_on       = 1'b0;
      dir_back      = 1'b0;
      step_results_q.delete();
    end else begin
      // push first: a result never precedes its own item
      if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1)
        step_results_q.push_back(predict_step(in_ch.req_type, in_ch.byte_value));
      if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
        got = {out_ch.step_pulse, out_ch.direction, out_ch.axis_enabled,
               out_ch.stop_event, out_ch.command_end};
        if (step_results_q.size() == 0) begin
          report_failure("result transfer with nothing expected");
        end else begin
          want = step_results_q.pop_front();
          check_field("step_pulse", want.pulse, got.pulse);
          check_field("direction", want.dir, got.dir);
          check_field("axis_enabled", want.en, got.en);
          check_field("stop_event", want.stop, got.stop);
          check_field("command_end", want.cmd_end, got.cmd_end);
        end
        result_idx++;
      end
    end
    due_n = step_results_q.size();
  end

  initial begin
    mismatches = 0;
    due_n      = 0;
    result_idx = 0;
  end

endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import scps_pkg::*;

  localparam int ITEM_TARGET  = 1230;
  localparam int LIMIT_CYCLES = 100000;
  localparam int HOLD_AT      = 300;
  localparam int HOLD_CYCLES  = 200;
  localparam int DRAIN_CYCLES = 5;

  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_ALL1  = 8'hFF;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  logic clk;
  logic rst_n;
  int   error_count;
  int   results_due;
  int   items_sent;
  int   rx_count;
  int   cycles;
  bit   no_idle;

  scps_in_if  in_ch ();
  scps_out_if out_ch ();

  stepper_command_parser_stepgen_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  scps_step_checker step_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .error_count (error_count),
    .results_due (results_due)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  task automatic send_item(input logic rt, input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.req_type   <= rt;
    in_ch.byte_value <= b;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    items_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_item(REQ_BYTE, b);
  endtask

  // byte lane carries junk on ticks
  task automatic send_tick();
    send_item(REQ_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic send_number_load();
    int pick;
    int ndig;
    send_byte(CHAR_S);
    if ($urandom_range(0, 9) == 0) begin
      pick = $urandom_range(0, 2);
      send_byte(pick == 0 ? CHAR_MINUS : (pick == 1 ? CHAR_PLUS : CHAR_SPACE));
    end
    pick = $urandom_range(0, 19);
    if (pick == 0)      ndig = 0;
    else if (pick == 1) ndig = $urandom_range(10, 12);
    else if (pick < 4)  ndig = 2;
    else                ndig = 1;
    repeat (ndig) send_byte(CHAR_ZERO + 8'($urandom_range(0, 9)));
    // trailing bytes after the digits are ignored, bar included
    if ($urandom_range(0, 4) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        pick = $urandom_range(0, 255);
        send_byte(8'(pick) == CHAR_S ? CHAR_BAR : 8'(pick));
      end
    end
    if ($urandom_range(0, 19) != 0) send_byte(CHAR_S);
  endtask

  initial begin : stimulus
    int kind;
    in_ch.valid      <= 1'b0;
    in_ch.req_type   <= REQ_BYTE;
    in_ch.byte_value <= CHAR_NUL;
    rst_n            <= 1'b0;
    no_idle = 1'b0;
    items_sent = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    send_tick();
    send_byte(CHAR_E); send_byte(CHAR_ONE);
    send_byte(CHAR_D); send_byte(CHAR_ZERO);
    send_byte(CHAR_S); send_byte(CHAR_ZERO + 8'd2); send_byte(CHAR_S);
    repeat (3) send_tick();
    send_byte(CHAR_BAR);
    send_byte(CHAR_E); send_byte(CHAR_D); send_byte(CHAR_ONE);
    send_byte(CHAR_S); send_byte(CHAR_MINUS); send_byte(CHAR_BAR); send_byte(CHAR_S);
    send_byte(CHAR_ALL1); send_byte(CHAR_NUL);
    send_byte(CHAR_S);
    repeat (10) send_byte(CHAR_NINE);
    send_byte(CHAR_S);

    while (items_sent < ITEM_TARGET) begin
      if ($urandom_range(0, 19) == 0) no_idle = !no_idle;
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
        send_byte(CHAR_E);
        send_byte($urandom_range(0, 1) ? CHAR_ONE : 8'($urandom_range(0, 255)));
      end else if (kind < 5) begin
        send_byte(CHAR_D);
        send_byte($urandom_range(0, 1) ? CHAR_ONE : 8'($urandom_range(0, 255)));
      end else if (kind < 10) begin
        send_number_load();
      end else if (kind < 17) begin
        repeat ($urandom_range(1, 10)) send_tick();
      end else if (kind == 17) begin
        send_byte(CHAR_BAR);
      end else if ($urandom_range(0, 1)) begin
        send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_tick();
      end
    end

    in_ch.valid <= 1'b0;
    // let the checker count the last transfer before polling
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0 && results_due == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  initial begin : result_sink
    int stall;
    rx_count = 0;
    out_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      // one long hold-off lets the block fill and stall its input
      if (rx_count == HOLD_AT) stall = HOLD_CYCLES;
      else                     stall = no_idle ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (out_ch.valid !== 1'b1) @(posedge clk);
      rx_count++;
    end
  end

  initial begin : watchdog
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("tb: done, errors");
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/scps_pkg.sv
design/scps_in_if.sv
design/scps_out_if.sv
design/scps_parser.sv
design/stepper_command_parser_stepgen_core.sv
design/scps_checker.sv
sim/scps_step_checker.sv
sim/tb.sv
